// File: src/gamepad_poll_frame_decoder_assert.svh
// Assertion macros for the gamepad poll-frame decoder.
// Included by RTL files that carry concurrent checks; needs no package.
`ifndef GAMEPAD_POLL_FRAME_DECODER_ASSERT_SVH
`define GAMEPAD_POLL_FRAME_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define GPFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gpfd: same-cycle check failed");
`define GPFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gpfd: next-cycle check failed");
`else
`define GPFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GPFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: src/gpfd_pkg.sv
// Shared types and constants of the gamepad poll-frame decoder.
// No dependencies; used by gpfd_decode and gamepad_poll_frame_decoder.
`timescale 1ns / 1ps

package gpfd_pkg;

	localparam logic [7:0] ACK_BYTE  = 8'h5a;
	localparam logic [7:0] CMD_POLL  = 8'h42;
	localparam logic [7:0] CMD_IDLE  = 8'hff;
	localparam logic [7:0] AXIS_FLIP = 8'h80;

	localparam logic [7:0] ID_DIGITAL_RST = 8'd65;
	localparam logic [7:0] ID_RED_RST     = 8'd115;
	localparam logic [7:0] ID_GREEN_RST   = 8'd83;
	localparam logic [7:0] ID_STEER_RST   = 8'd35;

	localparam logic [1:0] CFG_ID_DIGITAL = 2'd0;
	localparam logic [1:0] CFG_ID_RED     = 2'd1;
	localparam logic [1:0] CFG_ID_GREEN   = 2'd2;
	localparam logic [1:0] CFG_ID_STEER   = 2'd3;

	typedef enum logic [8:0] {
		POS_IDLE = 9'b000000001,
		POS_TYPE = 9'b000000010,
		POS_ACK  = 9'b000000100,
		POS_BTN0 = 9'b000001000,
		POS_BTN1 = 9'b000010000,
		POS_TR0  = 9'b000100000,
		POS_TR1  = 9'b001000000,
		POS_TR2  = 9'b010000000,
		POS_TR3  = 9'b100000000
	} pos_t;

	typedef enum logic [2:0] {
		CLS_NONE    = 3'd0,
		CLS_DIGITAL = 3'd1,
		CLS_RED     = 3'd2,
		CLS_GREEN   = 3'd3,
		CLS_STEER   = 3'd4
	} cls_t;

	typedef enum logic [1:0] {
		ST_CONT  = 2'd0,
		ST_DONE  = 2'd1,
		ST_ABORT = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] digital;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] steer;
	} ids_t;

	typedef struct packed {
		pos_t            pos;
		cls_t            cls;
		logic [7:0]      face;
		logic [3:0]      sys;
		logic [3:0]      hat;
		logic [3:0][7:0] axis;
		logic [2:0][7:0] press;
	} frame_state_t;

endpackage

// File: src/gamepad_poll_frame_decoder.sv
// Top level of the gamepad poll-frame decoder: input register, frame state,
// result register and type-byte registers. Depends on gpfd_pkg, gpfd_decode
// and gamepad_poll_frame_decoder_assert.svh.
`timescale 1ns / 1ps
`include "gamepad_poll_frame_decoder_assert.svh"

// Takes one received byte per cycle while the output side is ready, a rate
// set by the single decode stage between the input register and the
// frame-state and result registers, and returns one result per byte from
// the result register. The frame state is updated in the same cycle the
// result is loaded, so the next byte sees it at once.
// Type-byte registers are written through the cfg channel, which is always
// ready; write them only while no item is in flight.
module gamepad_poll_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte[7:0]
	input  logic        s_tuser,   // frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	// next_command[7:0], face_buttons[15:8], system_buttons[19:16],
	// hat_bits[23:20], right_x[31:24], right_y[39:32], left_x[47:40],
	// left_y[55:48], press_one[63:56], press_two[71:64], press_shoulder[79:72]
	output logic [79:0] m_tdata,
	output logic [1:0]  m_tuser,   // frame_status[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic                   valid_s1;
	logic [7:0]             rx_s1;
	logic                   start_s1;
	logic                   out_valid_q;
	logic [7:0]             cmd_q;
	gpfd_pkg::status_t      status_q;
	gpfd_pkg::frame_state_t state_q;
	gpfd_pkg::frame_state_t state_nxt;
	gpfd_pkg::ids_t         ids_q;
	logic [7:0]             cmd_nxt;
	gpfd_pkg::status_t      status_nxt;
	logic                   adv;
	logic                   item_go;

	assign adv       = !out_valid_q || m_tready;
	assign item_go   = valid_s1 && adv;
	assign s_tready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	gpfd_decode u_decode (
		.cur    (state_q),
		.ids    (ids_q),
		.rx     (rx_s1),
		.start  (start_s1),
		.nxt    (state_nxt),
		.cmd    (cmd_nxt),
		.status (status_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rx_s1    <= '0;
			start_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
			if (s_tvalid) begin
				rx_s1    <= s_tdata;
				start_s1 <= s_tuser;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cmd_q       <= gpfd_pkg::CMD_IDLE;
			status_q    <= gpfd_pkg::ST_CONT;
			state_q     <= '{pos: gpfd_pkg::POS_IDLE, cls: gpfd_pkg::CLS_NONE, default: '0};
		end else begin
			if (adv) begin
				out_valid_q <= valid_s1;
			end
			if (item_go) begin
				cmd_q    <= cmd_nxt;
				status_q <= status_nxt;
				state_q  <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ids_q <= '{digital: gpfd_pkg::ID_DIGITAL_RST, red: gpfd_pkg::ID_RED_RST,
				green: gpfd_pkg::ID_GREEN_RST, steer: gpfd_pkg::ID_STEER_RST};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				gpfd_pkg::CFG_ID_DIGITAL: ids_q.digital <= cfg_data;
				gpfd_pkg::CFG_ID_RED:     ids_q.red     <= cfg_data;
				gpfd_pkg::CFG_ID_GREEN:   ids_q.green   <= cfg_data;
				gpfd_pkg::CFG_ID_STEER:   ids_q.steer   <= cfg_data;
				default:                  ids_q         <= ids_q;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {state_q.press, state_q.axis, state_q.hat, state_q.sys,
		state_q.face, cmd_q};

	`GPFD_ASSERT_NEXT(a_start_polls, clk, arst_n, item_go && start_s1,
		m_tvalid && m_tdata[7:0] == gpfd_pkg::CMD_POLL)
	`GPFD_ASSERT_NEXT(a_start_clears, clk, arst_n, item_go && start_s1,
		state_q.face == 8'd0 && state_q.sys == 4'd0 && state_q.hat == 4'd0)
	`GPFD_ASSERT_NEXT(a_end_idles, clk, arst_n, item_go && status_nxt != gpfd_pkg::ST_CONT,
		state_q.pos == gpfd_pkg::POS_IDLE)
	`GPFD_ASSERT_IMP(a_stall_holds_state, clk, arst_n, !adv, !item_go)

endmodule

// File: src/gpfd_decode.sv
// Next-state and command logic for one received byte of a poll frame.
// Depends on gpfd_pkg.
`timescale 1ns / 1ps

module gpfd_decode (
	input  gpfd_pkg::frame_state_t cur,
	input  gpfd_pkg::ids_t         ids,
	input  logic [7:0]             rx,
	input  logic                   start,
	output gpfd_pkg::frame_state_t nxt,
	output logic [7:0]             cmd,
	output gpfd_pkg::status_t      status
);

	gpfd_pkg::cls_t cls_id;
	logic           steer;
	logic [7:0]     nd;

	assign steer = (cur.cls == gpfd_pkg::CLS_STEER);
	assign nd    = ~rx;

	always_comb begin
		priority if (rx == ids.digital) begin
			cls_id = gpfd_pkg::CLS_DIGITAL;
		end else if (rx == ids.red) begin
			cls_id = gpfd_pkg::CLS_RED;
		end else if (rx == ids.green) begin
			cls_id = gpfd_pkg::CLS_GREEN;
		end else if (rx == ids.steer) begin
			cls_id = gpfd_pkg::CLS_STEER;
		end else begin
			cls_id = gpfd_pkg::CLS_NONE;
		end
	end

	always_comb begin
		nxt    = cur;
		cmd    = gpfd_pkg::CMD_IDLE;
		status = gpfd_pkg::ST_CONT;
		if (start) begin
			nxt.pos   = gpfd_pkg::POS_TYPE;
			nxt.face  = '0;
			nxt.sys   = '0;
			nxt.hat   = '0;
			nxt.axis  = '0;
			nxt.press = '0;
			cmd       = gpfd_pkg::CMD_POLL;
		end else begin
			unique case (cur.pos)
				gpfd_pkg::POS_IDLE: begin
					nxt.pos = gpfd_pkg::POS_IDLE;
				end
				gpfd_pkg::POS_TYPE: begin
					nxt.cls = cls_id;
					if (cls_id == gpfd_pkg::CLS_NONE) begin
						status  = gpfd_pkg::ST_ABORT;
						nxt.pos = gpfd_pkg::POS_IDLE;
					end else begin
						nxt.pos = gpfd_pkg::POS_ACK;
					end
				end
				gpfd_pkg::POS_ACK: begin
					if (rx != gpfd_pkg::ACK_BYTE) begin
						status  = gpfd_pkg::ST_ABORT;
						nxt.pos = gpfd_pkg::POS_IDLE;
					end else begin
						nxt.pos = gpfd_pkg::POS_BTN0;
					end
				end
				gpfd_pkg::POS_BTN0: begin
					nxt.sys[3] = cur.sys[3] | nd[3];
					if (!steer) begin
						nxt.sys[2] = cur.sys[2] | nd[0];
					end
					if (cur.cls == gpfd_pkg::CLS_RED) begin
						nxt.sys[0] = cur.sys[0] | nd[1];
						nxt.sys[1] = cur.sys[1] | nd[2];
					end
					if (cur.cls == gpfd_pkg::CLS_DIGITAL || cur.cls == gpfd_pkg::CLS_RED
							|| steer) begin
						nxt.hat = nd[7:4];
					end
					nxt.pos = gpfd_pkg::POS_BTN1;
				end
				gpfd_pkg::POS_BTN1: begin
					nxt.face[5] = cur.face[5] | nd[3];
					nxt.face[2] = cur.face[2] | nd[4];
					nxt.face[3] = cur.face[3] | nd[5];
					if (!steer) begin
						nxt.face[4] = cur.face[4] | nd[2];
						nxt.face[6] = cur.face[6] | nd[0];
						nxt.face[7] = cur.face[7] | nd[1];
						nxt.face[0] = cur.face[0] | nd[6];
						nxt.face[1] = cur.face[1] | nd[7];
					end
					if (cur.cls == gpfd_pkg::CLS_DIGITAL) begin
						status  = gpfd_pkg::ST_DONE;
						nxt.pos = gpfd_pkg::POS_IDLE;
					end else begin
						nxt.pos = gpfd_pkg::POS_TR0;
					end
				end
				gpfd_pkg::POS_TR0: begin
					if (steer) begin
						nxt.axis[2] = rx ^ gpfd_pkg::AXIS_FLIP;
					end else begin
						nxt.axis[0] = rx ^ gpfd_pkg::AXIS_FLIP;
					end
					nxt.pos = gpfd_pkg::POS_TR1;
				end
				gpfd_pkg::POS_TR1: begin
					if (steer) begin
						nxt.press[0] = rx;
					end else begin
						nxt.axis[1] = rx ^ gpfd_pkg::AXIS_FLIP;
					end
					nxt.pos = gpfd_pkg::POS_TR2;
				end
				gpfd_pkg::POS_TR2: begin
					if (steer) begin
						nxt.press[1] = rx;
					end else begin
						nxt.axis[2] = rx ^ gpfd_pkg::AXIS_FLIP;
					end
					nxt.pos = gpfd_pkg::POS_TR3;
				end
				gpfd_pkg::POS_TR3: begin
					if (steer) begin
						nxt.press[2] = rx;
					end else begin
						nxt.axis[3] = rx ^ gpfd_pkg::AXIS_FLIP;
					end
					status  = gpfd_pkg::ST_DONE;
					nxt.pos = gpfd_pkg::POS_IDLE;
				end
				default: begin
					nxt.pos = gpfd_pkg::POS_IDLE;
				end
			endcase
		end
	end

endmodule

// File: tb/tb_gamepad_poll_frame_decoder.sv
// Self-checking bench for gamepad_poll_frame_decoder: a directed table, then random
// poll frames under several type-byte settings, checked against a frame predictor.
// Depends on gpfd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_gamepad_poll_frame_decoder;

	import gpfd_pkg::*;

	typedef struct packed {
		logic [7:0]      cmd;
		status_t         status;
		logic [7:0]      face;
		logic [3:0]      sys;
		logic [3:0]      hat;
		logic [3:0][7:0] axis;
		logic [2:0][7:0] press;
	} pad_report_t;

	typedef struct packed {
		logic       start;
		logic [7:0] rx;
		logic       typed;
		logic [7:0] cmd;
		status_t    status;
	} poll_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_ID_DIGITAL;
	logic [7:0]  cfg_data = 8'h00;

	pad_report_t pending_reports[$];
	pad_report_t held;
	pos_t        pad_pos = POS_IDLE;
	cls_t        pad_cls = CLS_NONE;
	logic [7:0]  id_tab[4];
	int          errors = 0;
	int          n_results = 0;
	int          live_items = 0;
	int          tx_quiet = 0;
	int          rx_quiet = 0;
	int          rx_stall = 0;

	poll_row_t directed_rows[0:23] = '{
		'{1'b0, 8'h00, 1'b1, CMD_IDLE, ST_CONT},
		'{1'b1, 8'hff, 1'b1, CMD_POLL, ST_CONT},
		'{1'b0, 8'd65, 1'b0, CMD_IDLE, ST_CONT},
		'{1'b0, ACK_BYTE, 1'b0, CMD_IDLE, ST_CONT},
		'{1'b0, 8'h00, 1'b0, CMD_IDLE, ST_CONT},
		'{1'b0, 8'h00, 1'b1, CMD_IDLE, ST_DONE},
		'{1'b0, 8'hff, 1'b1, CMD_IDLE, ST_CONT},
		'{1'b1, 8'h00, 1'b1, CMD_POLL, ST_CONT},
		'{1'b0, 8'h99, 1'b1, CMD_IDLE, ST_ABORT},
		'{1'b1, 8'ha5, 1'b1, CMD_POLL, ST_CONT},
		'{1'b0, 8'd115, 1'b0, CMD_IDLE, ST_CONT},
		'{1'b0, 8'h00, 1'b1, CMD_IDLE, ST_ABORT},
		'{1'b1, 8'h00, 1'b1, CMD_POLL, ST_CONT},
		'{1'b0, 8'd115, 1'b0, CMD_IDLE, ST_CONT},
		'{1'b0, ACK_BYTE, 1'b0, CMD_IDLE, ST_CONT},
		'{1'b1, 8'h55, 1'b1, CMD_POLL, ST_CONT},
		'{1'b0, 8'd35, 1'b0, CMD_IDLE, ST_CONT},
		'{1'b0, ACK_BYTE, 1'b0, CMD_IDLE, ST_CONT},
		'{1'b0, 8'h00, 1'b0, CMD_IDLE, ST_CONT},
		'{1'b0, 8'hff, 1'b0, CMD_IDLE, ST_CONT},
		'{1'b0, 8'h00, 1'b0, CMD_IDLE, ST_CONT},
		'{1'b0, 8'hff, 1'b0, CMD_IDLE, ST_CONT},
		'{1'b0, 8'h80, 1'b0, CMD_IDLE, ST_CONT},
		'{1'b0, 8'h7f, 1'b1, CMD_IDLE, ST_DONE}
	};

	gamepad_poll_frame_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70)
			return 0;
		if (p < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] rand_byte();
		int p;
		p = $urandom_range(0, 19);
		if (p == 0)
			return 8'h00;
		if (p == 1)
			return 8'hff;
		return 8'($urandom);
	endfunction

	function automatic cls_t classify_type(input logic [7:0] t);
		if (t == id_tab[CFG_ID_DIGITAL])
			return CLS_DIGITAL;
		if (t == id_tab[CFG_ID_RED])
			return CLS_RED;
		if (t == id_tab[CFG_ID_GREEN])
			return CLS_GREEN;
		if (t == id_tab[CFG_ID_STEER])
			return CLS_STEER;
		return CLS_NONE;
	endfunction

	// advance the frame state by one received byte and return the report it yields
	function automatic pad_report_t predict_poll(input logic st, input logic [7:0] d);
		logic steer;
		cls_t c;
		int   slot;
		c = pad_cls;
		steer = (pad_cls == CLS_STEER);
		held.cmd = CMD_IDLE;
		held.status = ST_CONT;
		if (st) begin
			held.face = '0;
			held.sys = '0;
			held.hat = '0;
			held.axis = '0;
			held.press = '0;
			held.cmd = CMD_POLL;
			pad_pos = POS_TYPE;
		end else begin
			case (pad_pos)
				POS_TYPE: begin
					c = classify_type(d);
					pad_cls = c;
					if (c == CLS_NONE) begin
						held.status = ST_ABORT;
						pad_pos = POS_IDLE;
					end else begin
						pad_pos = POS_ACK;
					end
				end
				POS_ACK: begin
					if (d != ACK_BYTE) begin
						held.status = ST_ABORT;
						pad_pos = POS_IDLE;
					end else begin
						pad_pos = POS_BTN0;
					end
				end
				POS_BTN0: begin
					held.sys[3] |= ~d[3];
					if (!steer)
						held.sys[2] |= ~d[0];
					if (c == CLS_RED) begin
						held.sys[0] |= ~d[1];
						held.sys[1] |= ~d[2];
					end
					if (c == CLS_DIGITAL || c == CLS_RED || steer)
						held.hat = ~d[7:4];
					pad_pos = POS_BTN1;
				end
				POS_BTN1: begin
					held.face[5] |= ~d[3];
					held.face[2] |= ~d[4];
					held.face[3] |= ~d[5];
					if (!steer) begin
						held.face[4] |= ~d[2];
						held.face[6] |= ~d[0];
						held.face[7] |= ~d[1];
						held.face[0] |= ~d[6];
						held.face[1] |= ~d[7];
					end
					if (c == CLS_DIGITAL) begin
						held.status = ST_DONE;
						pad_pos = POS_IDLE;
					end else begin
						pad_pos = POS_TR0;
					end
				end
				POS_TR0, POS_TR1, POS_TR2, POS_TR3: begin
					case (pad_pos)
						POS_TR0: slot = 0;
						POS_TR1: slot = 1;
						POS_TR2: slot = 2;
						default: slot = 3;
					endcase
					if (steer) begin
						if (slot == 0)
							held.axis[2] = d ^ AXIS_FLIP;
						else
							held.press[slot - 1] = d;
					end else begin
						held.axis[slot] = d ^ AXIS_FLIP;
					end
					case (pad_pos)
						POS_TR0: pad_pos = POS_TR1;
						POS_TR1: pad_pos = POS_TR2;
						POS_TR2: pad_pos = POS_TR3;
						default: begin
							held.status = ST_DONE;
							pad_pos = POS_IDLE;
						end
					endcase
				end
				default: pad_pos = POS_IDLE;
			endcase
		end
		return held;
	endfunction

	task automatic flag_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		if (errors < 40)
			$display("mismatch on result %0d, %s: got %02h, expected %02h",
				n_results, what, got, want);
		errors++;
	endtask

	task automatic send_item(input logic st, input logic [7:0] b, input logic typed = 1'b0,
			input logic [7:0] tcmd = CMD_IDLE, input status_t tst = ST_CONT);
		pad_report_t r;
		int          g;
		if (st || pad_pos != POS_IDLE)
			live_items++;
		if (tx_quiet > 0) begin
			tx_quiet--;
		end else begin
			if ($urandom_range(0, 49) == 0)
				tx_quiet = $urandom_range(20, 100);
			g = pick_gap();
			if (g > 0) begin
				s_tvalid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
		r = predict_poll(st, b);
		if (typed) begin
			r.cmd = tcmd;
			r.status = tst;
		end
		pending_reports.push_back(r);
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= st;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic settle_idle();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		id_tab[idx] = val;
	endtask

	task automatic set_ids(input logic [7:0] dig, input logic [7:0] red,
			input logic [7:0] green, input logic [7:0] steer);
		write_reg(CFG_ID_DIGITAL, dig);
		write_reg(CFG_ID_RED, red);
		write_reg(CFG_ID_GREEN, green);
		write_reg(CFG_ID_STEER, steer);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly well-formed frames with random content; some noise, cut frames, bad type/ack
	task automatic random_frame();
		logic [7:0] b;
		if ($urandom_range(0, 99) < 6) begin
			send_item(1'b0, rand_byte());
			return;
		end
		send_item(1'b1, rand_byte());
		while (pad_pos != POS_IDLE) begin
			if ($urandom_range(0, 49) == 0)
				return;
			case (pad_pos)
				POS_TYPE: b = ($urandom_range(0, 9) != 0) ? id_tab[$urandom_range(0, 3)]
					: rand_byte();
				POS_ACK: b = ($urandom_range(0, 14) != 0) ? ACK_BYTE : rand_byte();
				default: b = rand_byte();
			endcase
			send_item(1'b0, b);
		end
		if ($urandom_range(0, 59) == 0)
			settle_idle();
	endtask

	task automatic run_phase(input int n);
		live_items = 0;
		while (live_items < n)
			random_frame();
		settle_idle();
	endtask

	always @(posedge clk) begin
		if (rx_quiet > 0) begin
			rx_quiet--;
			m_tready <= 1'b1;
		end else if (rx_stall > 0) begin
			rx_stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 199) == 0)
				rx_quiet = $urandom_range(50, 300);
			else if ($urandom_range(0, 3) == 0)
				rx_stall = pick_gap();
		end
	end

	always @(posedge clk) begin
		pad_report_t got;
		pad_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.cmd = m_tdata[7:0];
			got.face = m_tdata[15:8];
			got.sys = m_tdata[19:16];
			got.hat = m_tdata[23:20];
			for (int i = 0; i < 4; i++)
				got.axis[i] = m_tdata[24 + 8 * i +: 8];
			for (int i = 0; i < 3; i++)
				got.press[i] = m_tdata[56 + 8 * i +: 8];
			got.status = status_t'(m_tuser);
			if (pending_reports.size() == 0) begin
				flag_mismatch("result with none pending", got.cmd, 8'h00);
			end else begin
				want = pending_reports.pop_front();
				if (got.cmd !== want.cmd)
					flag_mismatch("next_command", got.cmd, want.cmd);
				if (got.status !== want.status)
					flag_mismatch("frame_status", 8'(got.status), 8'(want.status));
				if (got.face !== want.face)
					flag_mismatch("face_buttons", got.face, want.face);
				if (got.sys !== want.sys)
					flag_mismatch("system_buttons", 8'(got.sys), 8'(want.sys));
				if (got.hat !== want.hat)
					flag_mismatch("hat_bits", 8'(got.hat), 8'(want.hat));
				for (int i = 0; i < 4; i++)
					if (got.axis[i] !== want.axis[i])
						flag_mismatch($sformatf("axis %0d", i), got.axis[i], want.axis[i]);
				for (int i = 0; i < 3; i++)
					if (got.press[i] !== want.press[i])
						flag_mismatch($sformatf("pressure %0d", i), got.press[i],
							want.press[i]);
			end
			n_results++;
		end
	end

	initial begin
		#(10_000_000);
		$display("status: fail");
		$finish;
	end

	initial begin
		logic [7:0] r1;
		logic [7:0] r2;
		logic [7:0] r3;
		held = '0;
		id_tab[CFG_ID_DIGITAL] = ID_DIGITAL_RST;
		id_tab[CFG_ID_RED] = ID_RED_RST;
		id_tab[CFG_ID_GREEN] = ID_GREEN_RST;
		id_tab[CFG_ID_STEER] = ID_STEER_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].start, directed_rows[i].rx, directed_rows[i].typed,
				directed_rows[i].cmd, directed_rows[i].status);
		settle_idle();

		run_phase(300);

		set_ids(8'h00, 8'hff, 8'h80, 8'h7f);
		run_phase(350);

		r1 = 8'($urandom);
		set_ids(r1, r1, r1, r1);
		run_phase(300);

		r2 = r1 ^ 8'($urandom_range(1, 255));
		set_ids(r1, r2, r2, r2);
		run_phase(300);

		r3 = r2 ^ 8'($urandom_range(1, 255));
		set_ids(r1 ^ 8'hff, r2, r3, r3);
		run_phase(300);

		set_ids(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		run_phase(450);

		settle_idle();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+src
src/gpfd_pkg.sv
src/gpfd_decode.sv
src/gamepad_poll_frame_decoder.sv
tb/tb_gamepad_poll_frame_decoder.sv
